>>> src/slr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

   // GF(256) reduction polynomial 0x11D, without the x^8 term.
   localparam logic [7:0] GF_POLY_LOW = 8'h1D;
   // Exponent that gives the multiplicative inverse, a^254.
   localparam logic [7:0] INV_EXP = 8'd254;
   localparam int unsigned THRESH_W = 5;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd3;
   // Common width for comparing point counts against the threshold.
   localparam int unsigned CMP_W = 9;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_I,
      ST_LD_I,
      ST_J_NUM,
      ST_J_DEN,
      ST_J_RD,
      ST_SQ,
      ST_MUL_A,
      ST_TERM_A,
      ST_TERM_B,
      ST_OUT
   } slr_state_type;

endpackage

`default_nettype wire

>>> src/slr_gf_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module slr_gf_mul
   import slr_pkg::*;
(
   input  wire logic [7:0] op_a,
   input  wire logic [7:0] op_b,
   output logic      [7:0] product
);

   // Shift-and-add multiply, reducing the shifted operand at every step.
   always_comb begin
      logic [7:0] acc;
      logic [7:0] aa;
      acc = 8'h00;
      aa  = op_a;
      for (int b = 0; b < 8; b++) begin
         if (op_b[b]) begin
            acc = acc ^ aa;
         end
         if (aa[7]) begin
            aa = {aa[6:0], 1'b0} ^ GF_POLY_LOW;
         end else begin
            aa = {aa[6:0], 1'b0};
         end
      end
      product = acc;
   end

endmodule

`default_nettype wire

>>> src/slr_point_store.sv
`timescale 1ns / 1ps
`default_nettype none

module slr_point_store
   import slr_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned IW    = 4
)
(
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [IW-1:0] wr_addr,
   input  wire logic [7:0]    wr_x,
   input  wire logic [7:0]    wr_y,
   input  wire logic [IW-1:0] rd_addr,
   output logic      [7:0]    rd_x,
   output logic      [7:0]    rd_y
);

   logic [7:0] x_mem_ff [DEPTH];
   logic [7:0] y_mem_ff [DEPTH];
   logic [7:0] rd_x_ff;
   logic [7:0] rd_y_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem_ff[wr_addr] <= wr_x;
         y_mem_ff[wr_addr] <= wr_y;
      end
   end

   always_ff @(posedge clock) begin
      rd_x_ff <= x_mem_ff[rd_addr];
      rd_y_ff <= y_mem_ff[rd_addr];
   end

   assign rd_x = rd_x_ff;
   assign rd_y = rd_y_ff;

endmodule

`default_nettype wire

>>> src/shamir_lagrange_recover_gf256_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A share point that does not end a set is taken back to back while the unit is idle.
// A last point with too few stored points goes through ST_OUT to the registered result.
// Recovery runs over the first threshold stored points, all on one shared GF(256)
// multiplier, which also forms each a^254 inverse by square-and-multiply.
// Synchronous active-high reset: threshold 3, point count 0, no result
// pending; the point store contents are not cleared.

module shamir_lagrange_recover_gf256_unit
   import slr_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 16
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [15:0]         req_tdata,  // share_x [7:0], share_y [15:8]
   input  wire logic                req_tlast,  // last_share
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [7:0]          rsp_tdata,  // secret_byte [7:0]
   output logic                     rsp_tuser,  // too_few [0]
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [THRESH_W-1:0] csr_wdata
);

   localparam int unsigned CW = $clog2(MAX_POINTS + 1);
   localparam int unsigned IW = $clog2(MAX_POINTS);

   slr_state_type state_ff, state_in;

   logic [THRESH_W-1:0] thresh_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       i_ff, i_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [2:0]          bit_ff, bit_in;
   logic [7:0]          xi_ff, xi_in;
   logic [7:0]          yi_ff, yi_in;
   logic [7:0]          num_ff, num_in;
   logic [7:0]          den_ff, den_in;
   logic [7:0]          pow_ff, pow_in;
   logic [7:0]          sum_ff, sum_in;
   logic                err_ff, err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_err_ff, rsp_err_in;

   logic          req_accept;
   logic          store_room;
   logic [CW-1:0] count_after;
   logic          short_set;
   logic          out_load;
   logic          j_is_i;
   logic          j_last;
   logic          i_last;
   logic [IW-1:0] rd_addr;
   logic [7:0]    rd_x;
   logic [7:0]    rd_y;
   logic [7:0]    mul_a;
   logic [7:0]    mul_b;
   logic [7:0]    mul_p;

   assign req_accept  = req_tvalid && req_tready;
   assign store_room  = CMP_W'(count_ff) < CMP_W'(MAX_POINTS);
   assign count_after = count_ff + CW'(store_room);
   assign short_set   = CMP_W'(count_after) < CMP_W'(thresh_ff);
   assign out_load    = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign j_is_i      = (j_ff == i_ff);
   assign j_last      = (CMP_W'(j_ff) + CMP_W'(1)) == CMP_W'(thresh_ff);
   assign i_last      = (CMP_W'(i_ff) + CMP_W'(1)) == CMP_W'(thresh_ff);

   slr_point_store #(
      .DEPTH (MAX_POINTS),
      .IW    (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept && store_room),
      .wr_addr (count_ff[IW-1:0]),
      .wr_x    (req_tdata[7:0]),
      .wr_y    (req_tdata[15:8]),
      .rd_addr (rd_addr),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   slr_gf_mul u_mul (
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_tlast) begin
               if (short_set || (thresh_ff == '0)) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_RD_I;
               end
            end
         end
         ST_RD_I:  state_in = ST_LD_I;
         ST_LD_I:  state_in = ST_J_NUM;
         ST_J_NUM: state_in = ST_J_DEN;
         ST_J_DEN: state_in = j_last ? ST_SQ : ST_J_RD;
         ST_J_RD:  state_in = ST_J_NUM;
         ST_SQ: begin
            if (INV_EXP[bit_ff]) begin
               state_in = ST_MUL_A;
            end else if (bit_ff == '0) begin
               state_in = ST_TERM_A;
            end
         end
         ST_MUL_A:  state_in = (bit_ff == '0) ? ST_TERM_A : ST_SQ;
         ST_TERM_A: state_in = ST_TERM_B;
         ST_TERM_B: state_in = i_last ? ST_OUT : ST_RD_I;
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and handshake outputs.
   always_comb begin
      count_in    = count_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      bit_in      = bit_ff;
      xi_in       = xi_ff;
      yi_in       = yi_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      pow_in      = pow_ff;
      sum_in      = sum_ff;
      err_in      = err_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_err_in  = rsp_err_ff;
      req_tready  = 1'b0;
      rd_addr     = j_ff[IW-1:0];
      mul_a       = num_ff;
      mul_b       = rd_x;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               count_in = req_tlast ? '0 : count_after;
               if (req_tlast) begin
                  i_in   = '0;
                  sum_in = 8'h00;
                  err_in = short_set;
               end
            end
         end
         ST_RD_I: begin
            rd_addr = i_ff[IW-1:0];
            j_in    = '0;
            num_in  = 8'h01;
            den_in  = 8'h01;
         end
         ST_LD_I: begin
            xi_in = rd_x;
            yi_in = rd_y;
         end
         ST_J_NUM: begin
            if (!j_is_i) begin
               num_in = mul_p;
            end
         end
         ST_J_DEN: begin
            mul_a = den_ff;
            mul_b = xi_ff ^ rd_x;
            if (!j_is_i) begin
               den_in = mul_p;
            end
            j_in = j_ff + CW'(1);
            if (j_last) begin
               pow_in = 8'h01;
               bit_in = 3'd7;
            end
         end
         ST_J_RD: begin
         end
         ST_SQ: begin
            mul_a  = pow_ff;
            mul_b  = pow_ff;
            pow_in = mul_p;
            if (!INV_EXP[bit_ff] && (bit_ff != '0)) begin
               bit_in = bit_ff - 3'd1;
            end
         end
         ST_MUL_A: begin
            mul_a  = pow_ff;
            mul_b  = den_ff;
            pow_in = mul_p;
            if (bit_ff != '0) begin
               bit_in = bit_ff - 3'd1;
            end
         end
         ST_TERM_A: begin
            mul_a  = num_ff;
            mul_b  = pow_ff;
            num_in = mul_p;
         end
         ST_TERM_B: begin
            mul_a  = yi_ff;
            mul_b  = num_ff;
            sum_in = sum_ff ^ mul_p;
            i_in   = i_ff + CW'(1);
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_byte_in = sum_ff;
               rsp_err_in  = err_ff;
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= THRESH_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            thresh_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      bit_ff      <= bit_in;
      xi_ff       <= xi_in;
      yi_ff       <= yi_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      pow_ff      <= pow_in;
      sum_ff      <= sum_in;
      err_ff      <= err_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_err_ff;

   // The store never holds more points than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(MAX_POINTS))
      else $error("point count exceeds store depth");

   // Requests are only taken while no recovery is running.
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request accepted during recovery");

   // A set ends with the point count cleared.
   a_set_clear: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (count_ff == '0))
      else $error("point count not cleared after last share");

   // An error result always carries a zero byte.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_byte_ff == 8'h00))
      else $error("too_few result with nonzero byte");

   // The inner index stays within the threshold while products are formed.
   a_j_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_J_NUM) |-> (CMP_W'(j_ff) < CMP_W'(thresh_ff)))
      else $error("inner index out of range");

endmodule

`default_nettype wire
